FILE: sv/ets_pkg.sv
package ets_pkg;

    // default width of the time registers
    localparam int TIME_BITS_DEF = 24;

    // input field widths
    localparam int CMD_W   = 3;
    localparam int DELTA_W = 16;
    localparam int DIL_W   = 16;

    // scaled delta: (delta * dilation + half) >> frac
    localparam int SCALED_W = 24;
    localparam int DIL_FRAC = 8;
    localparam logic [DELTA_W+DIL_W-1:0] DIL_HALF = (DELTA_W+DIL_W)'(128);

    // progress in q1.16: 16 fraction bits and one integer bit, so one is representable
    localparam int PROG_BITS = 16;
    localparam int PROG_W    = PROG_BITS + 1;
    localparam logic [PROG_W-1:0] PROG_ONE = {1'b1, {PROG_BITS{1'b0}}};

    localparam int LIMIT_W = 9;
    localparam int REPS_W  = 8;

    typedef enum logic [2:0] {
        CMD_INIT   = 3'd0,
        CMD_PLAY   = 3'd1,
        CMD_PAUSE  = 3'd2,
        CMD_RESUME = 3'd3,
        CMD_STOP   = 3'd4,
        CMD_TICK   = 3'd5,
        CMD_RESET  = 3'd6
    } cmd_code_t;

    typedef enum logic [2:0] {
        PH_UNINIT = 3'd0,
        PH_IDLE   = 3'd1,
        PH_DELAY  = 3'd2,
        PH_RUN    = 3'd3,
        PH_PAUSED = 3'd4,
        PH_COOL   = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        REG_RUN_LENGTH      = 3'd0,
        REG_START_DELAY     = 3'd1,
        REG_COOLDOWN_LENGTH = 3'd2,
        REG_REPEAT_GAP      = 3'd3,
        REG_REPEAT_LIMIT    = 3'd4,
        REG_REPEAT_ENDLESS  = 3'd5,
        REG_SCALED_TIME     = 3'd6,
        REG_DIRECTION_MODE  = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DIR_FOLLOW   = 2'd0,
        DIR_OPPOSITE = 2'd1,
        DIR_FORWARD  = 2'd2,
        DIR_BACKWARD = 2'd3
    } dir_mode_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic scale;
        logic update;
        logic prep;
        logic div_step;
        logic publish;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

FILE: sv/ets_ctrl.sv
module ets_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output ets_pkg::dp_cmd_t dp_cmd,
    input  ets_pkg::dp_stat_t dp_stat
);
    import ets_pkg::*;

    localparam int CNT_W = $clog2(PROG_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PROG_BITS - 1);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SCALE  = 6'b000010,
        ST_UPDATE = 6'b000100,
        ST_PREP   = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dp_cmd     = '0;
        case (state_reg)
            ST_IDLE:
            begin
                dp_cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                dp_cmd.scale = 1'b1;
                state_next   = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                dp_cmd.update = 1'b1;
                state_next    = ST_PREP;
            end
            ST_PREP:
            begin
                dp_cmd.prep = 1'b1;
                cnt_next    = '0;
                state_next  = ST_DIV;
            end
            ST_DIV:
            begin
                dp_cmd.div_step = 1'b1;
                cnt_next        = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                dp_cmd.publish = dp_stat.out_free;
                if (dp_stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: sv/ets_datapath.sv
module ets_datapath #(
    parameter int TIME_BITS = ets_pkg::TIME_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ets_pkg::dp_cmd_t             dp_cmd,
    output ets_pkg::dp_stat_t            dp_stat,
    input  logic                         cfg_write,
    input  logic [2:0]                   cfg_index,
    input  logic [TIME_BITS-1:0]         cfg_data,
    input  logic [ets_pkg::CMD_W-1:0]    cmd,
    input  logic [ets_pkg::DELTA_W-1:0]  delta_time,
    input  logic [ets_pkg::DIL_W-1:0]    dilation,
    input  logic                         owner_direction,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [2:0]                   phase,
    output logic                         play_event,
    output logic                         pause_event,
    output logic                         resume_event,
    output logic                         stop_event,
    output logic                         stop_interrupted,
    output logic                         step_event,
    output logic                         tick_active,
    output logic                         cooling,
    output logic                         backward,
    output logic [ets_pkg::PROG_W-1:0]   progress
);
    import ets_pkg::*;

    localparam int E   = TIME_BITS + 3;
    localparam int SW0 = (E > SCALED_W + 1) ? E : SCALED_W + 1;
    localparam int SW  = SW0 + 1;
    localparam logic [SW-1:0] EMAX_W = {{(SW-TIME_BITS-2){1'b0}}, {(TIME_BITS+2){1'b1}}};
    localparam logic [E-1:0]  EMAX_E = {1'b0, {(TIME_BITS+2){1'b1}}};

    typedef enum logic [1:0] {
        PSEL_ZERO = 2'd0,
        PSEL_FULL = 2'd1,
        PSEL_DIV  = 2'd2
    } psel_t;

    typedef struct packed {
        logic play;
        logic pause;
        logic resume;
        logic stop;
        logic intr;
        logic step;
        logic tick;
        logic cool;
    } ev_t;

    // configuration
    logic [TIME_BITS-1:0]      rl_reg, sd_reg, cl_reg, gap_reg;
    logic signed [LIMIT_W-1:0] lim_reg;
    logic                      endless_reg, scaled_reg;
    logic [1:0]                dmode_reg;

    // captured transaction and scaled delta
    logic [CMD_W-1:0]    cmd_reg;
    logic [DELTA_W-1:0]  delta_reg;
    logic [DIL_W-1:0]    dil_reg;
    logic                owner_reg;
    logic [SCALED_W-1:0] d_reg;

    // lifecycle state
    phase_t              ph_reg, ph_next;
    logic signed [E-1:0] el_reg, el_next;
    logic [REPS_W-1:0]   rd_reg, rd_next;
    logic                pp_reg, pp_next;
    logic                dir_reg, dir_next;
    ev_t                 ev_reg, ev_next;

    // progress divider
    psel_t                psel_reg;
    logic [TIME_BITS-1:0] rem_reg;
    logic [PROG_BITS-1:0] q_reg;

    // result register
    logic              out_valid_reg;
    logic [2:0]        o_phase_reg;
    ev_t               o_ev_reg;
    logic              o_bwd_reg;
    logic [PROG_W-1:0] o_prog_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rl_reg      <= '0;
            sd_reg      <= '0;
            cl_reg      <= '0;
            gap_reg     <= '0;
            lim_reg     <= '0;
            endless_reg <= 1'b0;
            scaled_reg  <= 1'b1;
            dmode_reg   <= DIR_FOLLOW;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_RUN_LENGTH:      rl_reg      <= cfg_data;
                REG_START_DELAY:     sd_reg      <= cfg_data;
                REG_COOLDOWN_LENGTH: cl_reg      <= cfg_data;
                REG_REPEAT_GAP:      gap_reg     <= cfg_data;
                REG_REPEAT_LIMIT:    lim_reg     <= $signed(cfg_data[LIMIT_W-1:0]);
                REG_REPEAT_ENDLESS:  endless_reg <= cfg_data[0];
                REG_SCALED_TIME:     scaled_reg  <= cfg_data[0];
                REG_DIRECTION_MODE:  dmode_reg   <= cfg_data[1:0];
                default:             rl_reg      <= rl_reg;
            endcase
        end
    end

    // input capture and delta scaling
    logic [DELTA_W+DIL_W-1:0] prod;
    assign prod = delta_reg * dil_reg + DIL_HALF;

    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            cmd_reg   <= cmd;
            delta_reg <= delta_time;
            dil_reg   <= dilation;
            owner_reg <= owner_direction;
        end
        if (dp_cmd.scale)
        begin
            d_reg <= scaled_reg ? prod[DIL_FRAC +: SCALED_W] : SCALED_W'(delta_reg);
        end
    end

    // state update
    logic signed [E-1:0]  rl_s, rewind_el, gap_neg, cool_end, adv_el;
    logic signed [SW-1:0] sum;
    logic                 rl_zero, run_done, dir_sel, lim_pos, rep_ok;

    assign rl_s      = $signed({3'b000, rl_reg});
    assign rewind_el = -$signed({3'b000, sd_reg});
    assign gap_neg   = -$signed({3'b000, gap_reg});
    assign cool_end  = $signed({2'b00, {1'b0, rl_reg} + {1'b0, cl_reg}});
    assign rl_zero   = (rl_reg == '0);
    assign sum       = $signed({{(SW-E){el_reg[E-1]}}, el_reg})
                     + $signed({{(SW-SCALED_W){1'b0}}, d_reg});
    assign adv_el    = rl_zero ? el_reg
                     : (sum > $signed(EMAX_W)) ? $signed(EMAX_E) : sum[E-1:0];
    assign run_done  = rl_zero || (adv_el >= rl_s);
    assign lim_pos   = !lim_reg[LIMIT_W-1] && (lim_reg[REPS_W-1:0] != '0);

    always_comb
    begin
        case (dir_mode_t'(dmode_reg))
            DIR_FOLLOW:   dir_sel = owner_reg;
            DIR_OPPOSITE: dir_sel = !owner_reg;
            DIR_FORWARD:  dir_sel = 1'b0;
            default:      dir_sel = 1'b1;
        endcase
    end

    always_comb
    begin
        ph_next  = ph_reg;
        el_next  = el_reg;
        rd_next  = rd_reg;
        pp_next  = pp_reg;
        dir_next = dir_reg;
        ev_next  = '0;
        rep_ok   = 1'b0;
        case (cmd_code_t'(cmd_reg))
            CMD_INIT:
            begin
                el_next  = rewind_el;
                dir_next = dir_sel;
                pp_next  = 1'b0;
                ph_next  = PH_IDLE;
            end
            CMD_PLAY:
            begin
                if (ph_reg == PH_COOL)
                begin
                    pp_next = 1'b1;
                end
                else if (ph_reg == PH_IDLE)
                begin
                    if (sd_reg != '0)
                    begin
                        ph_next = PH_DELAY;
                    end
                    else
                    begin
                        dir_next     = dir_sel;
                        ev_next.play = 1'b1;
                        ph_next      = PH_RUN;
                    end
                end
            end
            CMD_PAUSE:
            begin
                if (ph_reg == PH_RUN)
                begin
                    ev_next.pause = 1'b1;
                    ph_next       = PH_PAUSED;
                end
                else if (ph_reg == PH_DELAY || ph_reg == PH_COOL)
                begin
                    ph_next = PH_PAUSED;
                end
            end
            CMD_RESUME:
            begin
                if (ph_reg == PH_PAUSED)
                begin
                    if (cl_reg != '0 && el_reg >= rl_s)
                    begin
                        ph_next = PH_COOL;
                    end
                    else if (el_reg < 0)
                    begin
                        ph_next = PH_DELAY;
                    end
                    else
                    begin
                        ev_next.resume = 1'b1;
                        ph_next        = PH_RUN;
                    end
                end
            end
            CMD_STOP:
            begin
                if (ph_reg == PH_RUN || ph_reg == PH_PAUSED)
                begin
                    ev_next.stop = 1'b1;
                    ev_next.intr = 1'b1;
                    if (cl_reg != '0)
                    begin
                        el_next      = rl_s;
                        ph_next      = PH_COOL;
                        ev_next.cool = 1'b1;
                    end
                    else
                    begin
                        el_next = rewind_el;
                        ph_next = PH_IDLE;
                    end
                end
                else if (ph_reg == PH_DELAY)
                begin
                    el_next = rewind_el;
                    ph_next = PH_IDLE;
                end
                else if (ph_reg == PH_COOL)
                begin
                    ev_next.cool = 1'b1;
                end
            end
            CMD_TICK:
            begin
                if (ph_reg == PH_RUN)
                begin
                    ev_next.step = 1'b1;
                    ev_next.tick = 1'b1;
                    el_next      = adv_el;
                    if (run_done)
                    begin
                        ev_next.stop = 1'b1;
                        if (endless_reg)
                        begin
                            el_next = gap_neg;
                            rep_ok  = 1'b1;
                        end
                        else if (lim_pos)
                        begin
                            if (rd_reg >= lim_reg[REPS_W-1:0])
                            begin
                                rd_next = '0;
                            end
                            else
                            begin
                                el_next = gap_neg;
                                rd_next = rd_reg + REPS_W'(1);
                                rep_ok  = 1'b1;
                            end
                        end
                        if (rep_ok)
                        begin
                            if (gap_reg != '0)
                            begin
                                ph_next = PH_DELAY;
                            end
                            else
                            begin
                                dir_next     = dir_sel;
                                ev_next.play = 1'b1;
                                ph_next      = PH_RUN;
                            end
                        end
                        else if (cl_reg != '0)
                        begin
                            ph_next = PH_COOL;
                        end
                        else
                        begin
                            el_next = rewind_el;
                            ph_next = PH_IDLE;
                        end
                    end
                end
                else if (ph_reg == PH_DELAY)
                begin
                    ev_next.tick = 1'b1;
                    el_next      = adv_el;
                    if (adv_el >= 0)
                    begin
                        dir_next     = dir_sel;
                        ev_next.play = 1'b1;
                        ph_next      = PH_RUN;
                    end
                end
                else if (ph_reg == PH_COOL)
                begin
                    ev_next.tick = 1'b1;
                    el_next      = adv_el;
                    if (adv_el >= cool_end)
                    begin
                        el_next = rewind_el;
                        pp_next = 1'b0;
                        if (!pp_reg)
                        begin
                            ph_next = PH_IDLE;
                        end
                        else if (sd_reg != '0)
                        begin
                            ph_next = PH_DELAY;
                        end
                        else
                        begin
                            dir_next     = dir_sel;
                            ev_next.play = 1'b1;
                            ph_next      = PH_RUN;
                        end
                    end
                end
            end
            CMD_RESET:
            begin
                if (ph_reg != PH_UNINIT)
                begin
                    el_next = '0;
                    ph_next = PH_UNINIT;
                end
            end
            default:
            begin
                ph_next = ph_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg  <= PH_UNINIT;
            el_reg  <= '0;
            rd_reg  <= '0;
            pp_reg  <= 1'b0;
            dir_reg <= 1'b0;
        end
        else if (dp_cmd.update)
        begin
            ph_reg  <= ph_next;
            el_reg  <= el_next;
            rd_reg  <= rd_next;
            pp_reg  <= pp_next;
            dir_reg <= dir_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.update)
        begin
            ev_reg <= ev_next;
        end
    end

    // restoring division of elapsed << 16 by run length, one quotient bit a step
    logic [TIME_BITS:0] rem2;
    logic               fits;
    assign rem2 = {rem_reg, 1'b0};
    assign fits = (rem2 >= {1'b0, rl_reg});

    always_ff @(posedge clk)
    begin
        if (dp_cmd.prep)
        begin
            rem_reg <= el_reg[TIME_BITS-1:0];
            q_reg   <= '0;
            if (rl_zero || el_reg >= rl_s)
            begin
                psel_reg <= PSEL_FULL;
            end
            else if (el_reg <= 0)
            begin
                psel_reg <= PSEL_ZERO;
            end
            else
            begin
                psel_reg <= PSEL_DIV;
            end
        end
        else if (dp_cmd.div_step)
        begin
            rem_reg <= fits ? TIME_BITS'(rem2 - {1'b0, rl_reg}) : rem2[TIME_BITS-1:0];
            q_reg   <= {q_reg[PROG_BITS-2:0], fits};
        end
    end

    logic [PROG_W-1:0] p_base, p_dir;

    always_comb
    begin
        case (psel_reg)
            PSEL_ZERO: p_base = '0;
            PSEL_FULL: p_base = PROG_ONE;
            default:   p_base = {1'b0, q_reg};
        endcase
    end

    assign p_dir = dir_reg ? PROG_ONE - p_base : p_base;

    // result register
    assign dp_stat.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (dp_cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.publish)
        begin
            o_phase_reg <= ph_reg;
            o_ev_reg    <= ev_reg;
            o_bwd_reg   <= dir_reg;
            o_prog_reg  <= p_dir;
        end
    end

    assign out_valid        = out_valid_reg;
    assign phase            = o_phase_reg;
    assign play_event       = o_ev_reg.play;
    assign pause_event      = o_ev_reg.pause;
    assign resume_event     = o_ev_reg.resume;
    assign stop_event       = o_ev_reg.stop;
    assign stop_interrupted = o_ev_reg.intr;
    assign step_event       = o_ev_reg.step;
    assign tick_active      = o_ev_reg.tick;
    assign cooling          = o_ev_reg.cool;
    assign backward         = o_bwd_reg;
    assign progress         = o_prog_reg;

endmodule

FILE: sv/effect_timing_sequencer.sv
// a new transaction is taken only once the last one is through; a 16-step restoring divider
//   turns elapsed time over run length into a q0.16 quotient for the progress
// the input side opens again while a finished result still waits on a stalled output
// reset (rst_n low, asynchronous): phase not initialized, elapsed, repeat count,
//   pending play and direction cleared, config registers zero except scaled time set
module effect_timing_sequencer #(
    parameter int TIME_BITS = ets_pkg::TIME_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration write port
    input  logic                         cfg_write,
    input  logic [2:0]                   cfg_index,
    input  logic [TIME_BITS-1:0]         cfg_data,
    // command channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [ets_pkg::CMD_W-1:0]    cmd,
    input  logic [ets_pkg::DELTA_W-1:0]  delta_time,
    input  logic [ets_pkg::DIL_W-1:0]    dilation,
    input  logic                         owner_direction,
    // result channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [2:0]                   phase,
    output logic                         play_event,
    output logic                         pause_event,
    output logic                         resume_event,
    output logic                         stop_event,
    output logic                         stop_interrupted,
    output logic                         step_event,
    output logic                         tick_active,
    output logic                         cooling,
    output logic                         backward,
    output logic [ets_pkg::PROG_W-1:0]   progress
);
    import ets_pkg::*;

    // sequencer steps: capture, scale delta, update lifecycle, divider prep,
    // 16 divide steps, publish into the output register
    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    ets_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .dp_cmd   (dp_cmd),
        .dp_stat  (dp_stat)
    );

    // datapath keeps config, lifecycle state, divider and the result register
    ets_datapath #(
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .dp_cmd           (dp_cmd),
        .dp_stat          (dp_stat),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .delta_time       (delta_time),
        .dilation         (dilation),
        .owner_direction  (owner_direction),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .phase            (phase),
        .play_event       (play_event),
        .pause_event      (pause_event),
        .resume_event     (resume_event),
        .stop_event       (stop_event),
        .stop_interrupted (stop_interrupted),
        .step_event       (step_event),
        .tick_active      (tick_active),
        .cooling          (cooling),
        .backward         (backward),
        .progress         (progress)
    );

    // one transaction at a time: an accepted command closes the input side
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input side open right after a transaction");

    // an interrupted flag only comes with a stop
    a_intr_has_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stop_interrupted |-> stop_event)
        else $error("stop_interrupted without stop_event");

    // play and resume events always leave the effect running
    a_play_runs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (play_event || resume_event) |-> phase == PH_RUN)
        else $error("play or resume event outside running phase");

    // a pause event leaves the effect paused
    a_pause_paused: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pause_event |-> phase == PH_PAUSED)
        else $error("pause event outside paused phase");

    // progress never passes complete
    a_prog_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> progress <= PROG_ONE)
        else $error("progress above one");

endmodule
